### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lfo_pkg.sv
`timescale 1ns / 1ps

package lfo_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SYNC   = 2'd1,
        OP_RETUNE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        WF_OFF = 3'd0,
        WF_SAW = 3'd1,
        WF_TRI = 3'd2,
        WF_COS = 3'd3,
        WF_SQR = 3'd4
    } wave_t;

    typedef enum logic [2:0] {
        REG_WAVEFORM   = 3'd0,
        REG_AMPLITUDE  = 3'd1,
        REG_LVL_OFFSET = 3'd2,
        REG_SYNC_MODE  = 3'd3,
        REG_TEMPO      = 3'd4,
        REG_RATE       = 3'd5,
        REG_SYNC_PHASE = 3'd6
    } reg_idx_t;

    // Constant divider geometry: 14-bit digits, remainder below an 18-bit divisor,
    // so one partial dividend fits 32 bits. Six digits cover the tempo dividend.
    localparam int DIG_W  = 14;
    localparam int DVD_W  = 84;
    localparam int DIVR_W = 18;
    localparam int CNT_W  = 3;
    localparam int RSH_W  = 6;

    // 60e6 / 2^18 reduces to 234375 / 2^10.
    localparam logic [DIVR_W-1:0] SYNC_DIVISOR = 18'd234375;
    localparam int                SYNC_SHIFT   = 10;
    // reciprocal floor(2^s / d) with s = 31 + floor(log2 d)
    localparam logic [RSH_W-1:0]  SYNC_RSHIFT  = 6'd48;
    localparam logic [31:0]       SYNC_RECIP   = 32'((64'd1 << 48) / 64'd234375);
    localparam logic [CNT_W-1:0]  SYNC_STEPS   = 3'd6;
    localparam logic [CNT_W-1:0]  LEVEL_STEPS  = 3'd2;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [31:0] COS_BIAS = 32'd32768;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  steps;
        logic [DIVR_W-1:0] divisor;
        logic [31:0]       recip;
        logic [RSH_W-1:0]  rshift;
    } div_req_t;

    // Quarter-wave cosine entry in Q15, Taylor series in Q30.
    function automatic logic [14:0] quarter_cos(input int unsigned r, input int unsigned cb);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        x    = (PI_Q30 * 64'(r)) >> (cb - 1);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) == 1) sum = sum - $signed(term);
            else              sum = sum + $signed(term);
        end
        if (sum < 0) sum = '0;
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) q = 64'd32767;
        return q[14:0];
    endfunction

endpackage

### rtl/lfo_if.sv
`timescale 1ns / 1ps

interface lfo_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] time_us;
    logic [31:0] new_free_step;

    modport source (output valid, op, time_us, new_free_step, input ready);
    modport sink   (input valid, op, time_us, new_free_step, output ready);
endinterface

interface lfo_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] level;
    logic [31:0] phase;

    modport source (output valid, level, phase, input ready);
    modport sink   (input valid, level, phase, output ready);
endinterface

### rtl/lfo_div.sv
`timescale 1ns / 1ps

// Division by a constant, one 14-bit quotient digit at a time:
// reciprocal multiply, subtract the digit times the divisor, then one correction.
module lfo_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lfo_pkg::div_req_t          req,
    input  logic [lfo_pkg::DVD_W-1:0]  dividend,
    output logic                       done,
    output logic [31:0]                quot
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_SUB  = 4'b0100,
        D_FIX  = 4'b1000
    } dstate_t;

    dstate_t                    state_reg, state_next;
    logic [lfo_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [lfo_pkg::DIVR_W-1:0] rem_reg, rem_next;
    logic [lfo_pkg::DIVR_W-1:0] divisor_reg, divisor_next;
    logic [31:0]                recip_reg, recip_next;
    logic [lfo_pkg::RSH_W-1:0]  rshift_reg, rshift_next;
    logic [31:0]                part_reg, part_next;
    logic [63:0]                prod_reg, prod_next;
    logic [lfo_pkg::DIG_W-1:0]  qhat_reg, qhat_next;
    logic [lfo_pkg::DIVR_W:0]   diff_reg, diff_next;
    logic [31:0]                quot_reg, quot_next;
    logic [lfo_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [31:0]                part;
    logic [lfo_pkg::DIG_W-1:0]  qhat;
    logic [31:0]                qd;
    logic [31:0]                diff;
    logic                       fix;
    logic [lfo_pkg::DIG_W-1:0]  qfix;

    // remainder on top of the next digit
    assign part = {rem_reg, dvd_reg[lfo_pkg::DVD_W-1 -: lfo_pkg::DIG_W]};
    // estimate is the digit or one below it
    assign qhat = lfo_pkg::DIG_W'(prod_reg >> rshift_reg);
    assign qd   = {{(32 - lfo_pkg::DIG_W){1'b0}}, qhat}
                * {{(32 - lfo_pkg::DIVR_W){1'b0}}, divisor_reg};
    assign diff = part_reg - qd;
    assign fix  = diff_reg >= {1'b0, divisor_reg};
    assign qfix = qhat_reg + {{(lfo_pkg::DIG_W-1){1'b0}}, fix};

    always_comb
    begin
        state_next   = state_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        recip_next   = recip_reg;
        rshift_next  = rshift_reg;
        part_next    = part_reg;
        prod_next    = prod_reg;
        qhat_next    = qhat_reg;
        diff_next    = diff_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    dvd_next     = dividend;
                    rem_next     = '0;
                    quot_next    = '0;
                    divisor_next = req.divisor;
                    recip_next   = req.recip;
                    rshift_next  = req.rshift;
                    cnt_next     = req.steps;
                    state_next   = D_MUL;
                end
            end
            D_MUL:
            begin
                part_next  = part;
                prod_next  = 64'(part) * 64'(recip_reg);
                dvd_next   = dvd_reg << lfo_pkg::DIG_W;
                state_next = D_SUB;
            end
            D_SUB:
            begin
                qhat_next  = qhat;
                diff_next  = diff[lfo_pkg::DIVR_W:0];
                state_next = D_FIX;
            end
            D_FIX:
            begin
                // bump the digit when the remainder still holds a divisor
                rem_next  = fix ? lfo_pkg::DIVR_W'(diff_reg - {1'b0, divisor_reg})
                                : diff_reg[lfo_pkg::DIVR_W-1:0];
                quot_next = {quot_reg[31-lfo_pkg::DIG_W:0], qfix};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == lfo_pkg::CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                    state_next = D_MUL;
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        recip_reg   <= recip_next;
        rshift_reg  <= rshift_next;
        part_reg    <= part_next;
        prod_reg    <= prod_next;
        qhat_reg    <= qhat_next;
        diff_reg    <= diff_next;
        quot_reg    <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/lfo_waveform_generator_top.sv
`timescale 1ns / 1ps
// Multi-waveform LFO. Requests arrive on the item channel (valid/ready): op selects
// sample, phase sync or free-frequency retune, time_us stamps the request in
// microseconds. Only a sample request yields a result on the result channel: the
// DAC level and the UQ0.32 phase used for it.
// Settings (waveform, amplitude, center, mode, tempo, rate, synced offset) are
// written over the APB port at byte address 4*index; pready is always high.
// The block takes one request at a time; ready is high only while the sequencer
// idles. Sync completes in the accepting cycle; retune then runs RT1, RT2 and RT3.
// A free-running sample runs FR1, FR2, LV0 and FIN (off, square), adds LV1, LV2
// (cosine) or LV1 to LV3 and a divider wait (saw, triangle); synced mode swaps
// FR1, FR2 for SY1 to SY3 and a divider wait. Steps share one 32x32 multiplier,
// used at most once per step, and one constant divider: reciprocal multiply,
// subtract and one correction per 14-bit digit (2 digits for the level scale, 6
// for the tempo phase). The cosine table is a constant built at elaboration.
// Reset restores all settings to their defaults, zeroes the phase state and
// empties the output register. A result waits in the output register while the
// receiver stalls; a new request is still taken, and its result holds in the
// last step until the output register frees.
module lfo_waveform_generator_top #(
    parameter int DAC_LEVELS     = 4096,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    lfo_item_if.sink            item,
    lfo_result_if.source        result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

`include "assert_macros.svh"

    localparam int LB      = $clog2(DAC_LEVELS);
    localparam int SW      = LB + 3;
    localparam int QB      = COS_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;

    // level scale divides by DAC_LEVELS-1 through floor(2^s / d), s = 31 + floor(log2 d)
    localparam int          LVL_SHIFT = 30 + $clog2(DAC_LEVELS);
    localparam logic [31:0] LVL_RECIP = 32'((64'd1 << LVL_SHIFT) / 64'(DAC_LEVELS - 1));

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_RT1  = 16'b0000_0000_0000_0010,
        S_RT2  = 16'b0000_0000_0000_0100,
        S_RT3  = 16'b0000_0000_0000_1000,
        S_FR1  = 16'b0000_0000_0001_0000,
        S_FR2  = 16'b0000_0000_0010_0000,
        S_SY1  = 16'b0000_0000_0100_0000,
        S_SY2  = 16'b0000_0000_1000_0000,
        S_SY3  = 16'b0000_0001_0000_0000,
        S_SYW  = 16'b0000_0010_0000_0000,
        S_LV0  = 16'b0000_0100_0000_0000,
        S_LV1  = 16'b0000_1000_0000_0000,
        S_LV2  = 16'b0001_0000_0000_0000,
        S_LV3  = 16'b0010_0000_0000_0000,
        S_LDIV = 16'b0100_0000_0000_0000,
        S_FIN  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // settings
    logic [2:0]  waveform_reg, waveform_next;
    logic [11:0] amplitude_reg, amplitude_next;
    logic [11:0] level_offset_reg, level_offset_next;
    logic        synced_mode_reg, synced_mode_next;
    logic [15:0] tempo_bpm_reg, tempo_bpm_next;
    logic [15:0] rate_mult_reg, rate_mult_next;
    logic [31:0] sync_off_reg, sync_off_next;

    // phase state
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] free_off_reg, free_off_next;
    logic [31:0] free_step_reg, free_step_next;

    // working registers
    logic [31:0] elapsed_reg, elapsed_next;
    logic [31:0] new_step_reg, new_step_next;
    logic [31:0] tmp_reg, tmp_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] opnd_reg, opnd_next;
    logic [QB:0] cos_ent_reg, cos_ent_next;
    logic        cos_neg_reg, cos_neg_next;
    logic [63:0] prod_reg;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_level_reg, out_level_next;
    logic [31:0] out_phase_reg, out_phase_next;

    // shared multiplier
    logic        mul_en;
    logic [31:0] mul_a, mul_b;

    // shared divider
    lfo_pkg::div_req_t           div_req;
    logic [lfo_pkg::DVD_W-1:0]   div_dividend;
    logic                        div_done;
    logic [31:0]                 div_quot;

    logic cfg_wr;
    logic accept;

    lfo_pkg::wave_t wf_c;
    logic [31:0]          amp_u, off_u;
    logic signed [SW-1:0] amp_s, off_s, half_s, center_s, lvl_s, q_s, cos_s, v_s, sat_s;
    logic [SW-1:0]        sat_u;
    logic [63:0]          cterm;
    logic [31:0]          idx, idx2;
    logic [QB-1:0]        cos_r;

    logic [14:0] cos_tab [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_cos
        assign cos_tab[g] = lfo_pkg::quarter_cos(g, COS_TABLE_BITS);
    end

    lfo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid & item.ready;

    // wave geometry: clamp amp and center so the wave stays in range
    always_comb
    begin
        wf_c     = (waveform_reg > lfo_pkg::WF_SQR) ? lfo_pkg::WF_SQR
                                                    : lfo_pkg::wave_t'(waveform_reg);
        amp_u    = (32'(amplitude_reg) > 32'(DAC_LEVELS - 1)) ? 32'(DAC_LEVELS - 1)
                                                              : 32'(amplitude_reg);
        off_u    = (32'(level_offset_reg) > 32'(DAC_LEVELS - 1)) ? 32'(DAC_LEVELS - 1)
                                                                 : 32'(level_offset_reg);
        amp_s    = $signed(amp_u[SW-1:0]);
        off_s    = $signed(off_u[SW-1:0]);
        half_s   = amp_s >>> 1;
        lvl_s    = SW'(DAC_LEVELS);
        if (off_s < (lvl_s >>> 1))
            center_s = (off_s > half_s) ? off_s : half_s;
        else
            center_s = ((lvl_s - off_s) > half_s) ? off_s : lvl_s - half_s - SW'(1);
    end

    // final level from the sequencer results
    always_comb
    begin
        q_s   = $signed(div_quot[SW-1:0]);
        cterm = prod_reg >> 15;
        cos_s = $signed(cterm[SW-1:0]);
        case (wf_c)
            lfo_pkg::WF_OFF: v_s = off_s;
            lfo_pkg::WF_SAW: v_s = q_s + center_s - half_s;
            lfo_pkg::WF_TRI:
            begin
                if (phase_reg[31])
                begin
                    v_s = q_s + center_s - half_s - SW'(1);
                    if (v_s < 0) v_s = -v_s;
                end
                else
                    v_s = q_s + center_s - half_s;
            end
            lfo_pkg::WF_COS: v_s = center_s - half_s + cos_s;
            default:         v_s = phase_reg[31] ? center_s - half_s : center_s + half_s;
        endcase
        if (v_s < 0)                     sat_s = '0;
        else if (v_s > lvl_s - SW'(1))   sat_s = lvl_s - SW'(1);
        else                             sat_s = v_s;
        sat_u = sat_s;
    end

    assign idx   = prod_reg[63:32];
    assign idx2  = (idx >= 32'(DAC_LEVELS)) ? idx - 32'(DAC_LEVELS) : idx;
    assign cos_r = phase_reg[29 -: QB];

    always_comb
    begin
        state_next        = state_reg;
        waveform_next     = waveform_reg;
        amplitude_next    = amplitude_reg;
        level_offset_next = level_offset_reg;
        synced_mode_next  = synced_mode_reg;
        tempo_bpm_next    = tempo_bpm_reg;
        rate_mult_next    = rate_mult_reg;
        sync_off_next     = sync_off_reg;
        start_time_next   = start_time_reg;
        free_off_next     = free_off_reg;
        free_step_next    = free_step_reg;
        elapsed_next      = elapsed_reg;
        new_step_next     = new_step_reg;
        tmp_next          = tmp_reg;
        phase_next        = phase_reg;
        opnd_next         = opnd_reg;
        cos_ent_next      = cos_ent_reg;
        cos_neg_next      = cos_neg_reg;
        out_valid_next    = out_valid_reg & ~result.ready;
        out_level_next    = out_level_reg;
        out_phase_next    = out_phase_reg;
        mul_en            = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        div_req           = '{start: 1'b0, steps: '0, divisor: '0, recip: '0, rshift: '0};
        div_dividend      = '0;

        if (cfg_wr)
        begin
            unique case (lfo_pkg::reg_idx_t'(paddr[4:2]))
                lfo_pkg::REG_WAVEFORM:   waveform_next     = pwdata[2:0];
                lfo_pkg::REG_AMPLITUDE:  amplitude_next    = pwdata[11:0];
                lfo_pkg::REG_LVL_OFFSET: level_offset_next = pwdata[11:0];
                lfo_pkg::REG_SYNC_MODE:  synced_mode_next  = pwdata[0];
                lfo_pkg::REG_TEMPO:      tempo_bpm_next    = pwdata[15:0];
                lfo_pkg::REG_RATE:       rate_mult_next    = pwdata[15:0];
                lfo_pkg::REG_SYNC_PHASE: sync_off_next     = pwdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    elapsed_next  = item.time_us - start_time_reg;
                    new_step_next = item.new_free_step;
                    unique case (lfo_pkg::op_t'(item.op))
                        lfo_pkg::OP_SYNC:
                        begin
                            start_time_next = item.time_us;
                            free_off_next   = '0;
                        end
                        lfo_pkg::OP_RETUNE: state_next = S_RT1;
                        lfo_pkg::OP_SAMPLE: state_next = synced_mode_reg ? S_SY1 : S_FR1;
                        default: ;
                    endcase
                end
            end
            S_RT1:
            begin
                mul_en     = 1'b1;
                mul_a      = elapsed_reg;
                mul_b      = free_step_reg;
                state_next = S_RT2;
            end
            S_RT2:
            begin
                // hold the old phase, then weigh elapsed by the new step
                tmp_next   = prod_reg[31:0] + free_off_reg;
                mul_en     = 1'b1;
                mul_a      = elapsed_reg;
                mul_b      = new_step_reg;
                state_next = S_RT3;
            end
            S_RT3:
            begin
                free_off_next  = tmp_reg - prod_reg[31:0];
                free_step_next = new_step_reg;
                state_next     = S_IDLE;
            end
            S_FR1:
            begin
                mul_en     = 1'b1;
                mul_a      = elapsed_reg;
                mul_b      = free_step_reg;
                state_next = S_FR2;
            end
            S_FR2:
            begin
                phase_next = prod_reg[31:0] + free_off_reg;
                state_next = S_LV0;
            end
            S_SY1:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(tempo_bpm_reg);
                mul_b      = 32'(rate_mult_reg);
                state_next = S_SY2;
            end
            S_SY2:
            begin
                mul_en     = 1'b1;
                mul_a      = elapsed_reg;
                mul_b      = prod_reg[31:0];
                state_next = S_SY3;
            end
            S_SY3:
            begin
                div_req      = '{start: 1'b1, steps: lfo_pkg::SYNC_STEPS,
                                 divisor: lfo_pkg::SYNC_DIVISOR,
                                 recip: lfo_pkg::SYNC_RECIP,
                                 rshift: lfo_pkg::SYNC_RSHIFT};
                div_dividend = {lfo_pkg::SYNC_SHIFT'(0), prod_reg, lfo_pkg::SYNC_SHIFT'(0)};
                state_next   = S_SYW;
            end
            S_SYW:
            begin
                if (div_done)
                begin
                    phase_next = div_quot + sync_off_reg;
                    state_next = S_LV0;
                end
            end
            S_LV0:
            begin
                case (wf_c)
                    lfo_pkg::WF_SAW:
                    begin
                        mul_en     = 1'b1;
                        mul_a      = phase_reg;
                        mul_b      = 32'(DAC_LEVELS);
                        state_next = S_LV1;
                    end
                    lfo_pkg::WF_TRI:
                    begin
                        mul_en     = 1'b1;
                        mul_a      = phase_reg;
                        mul_b      = 32'(2 * DAC_LEVELS);
                        state_next = S_LV1;
                    end
                    lfo_pkg::WF_COS:
                    begin
                        // fold the phase onto the quarter table
                        cos_ent_next = phase_reg[30] ? (QB+1)'(QUARTER) - {1'b0, cos_r}
                                                     : {1'b0, cos_r};
                        cos_neg_next = phase_reg[31] ^ phase_reg[30];
                        state_next   = S_LV1;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_LV1:
            begin
                if (wf_c == lfo_pkg::WF_COS)
                    opnd_next = cos_neg_reg ? lfo_pkg::COS_BIAS - 32'(cos_tab[cos_ent_reg])
                                            : lfo_pkg::COS_BIAS + 32'(cos_tab[cos_ent_reg]);
                else if (wf_c == lfo_pkg::WF_TRI && phase_reg[31])
                    opnd_next = idx2;
                else
                    opnd_next = 32'(DAC_LEVELS - 1) - idx2;
                state_next = S_LV2;
            end
            S_LV2:
            begin
                mul_en = 1'b1;
                mul_b  = opnd_reg;
                if (wf_c == lfo_pkg::WF_COS)
                begin
                    mul_a      = 32'($unsigned(half_s));
                    state_next = S_FIN;
                end
                else
                begin
                    mul_a      = amp_u;
                    state_next = S_LV3;
                end
            end
            S_LV3:
            begin
                // amp times a level index stays below 2^28: two digits
                div_req      = '{start: 1'b1, steps: lfo_pkg::LEVEL_STEPS,
                                 divisor: lfo_pkg::DIVR_W'(DAC_LEVELS - 1),
                                 recip: LVL_RECIP,
                                 rshift: lfo_pkg::RSH_W'(LVL_SHIFT)};
                div_dividend = {prod_reg[27:0], (lfo_pkg::DVD_W - 28)'(0)};
                state_next   = S_LDIV;
            end
            S_LDIV:
            begin
                if (div_done) state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold here until the output register frees
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = 12'(32'(sat_u));
                    out_phase_next = phase_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        case (lfo_pkg::reg_idx_t'(paddr[4:2]))
            lfo_pkg::REG_WAVEFORM:   prdata = 32'(waveform_reg);
            lfo_pkg::REG_AMPLITUDE:  prdata = 32'(amplitude_reg);
            lfo_pkg::REG_LVL_OFFSET: prdata = 32'(level_offset_reg);
            lfo_pkg::REG_SYNC_MODE:  prdata = 32'(synced_mode_reg);
            lfo_pkg::REG_TEMPO:      prdata = 32'(tempo_bpm_reg);
            lfo_pkg::REG_RATE:       prdata = 32'(rate_mult_reg);
            lfo_pkg::REG_SYNC_PHASE: prdata = sync_off_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            waveform_reg     <= lfo_pkg::WF_OFF;
            amplitude_reg    <= 12'd4095;
            level_offset_reg <= '0;
            synced_mode_reg  <= 1'b0;
            tempo_bpm_reg    <= '0;
            rate_mult_reg    <= '0;
            sync_off_reg     <= '0;
            start_time_reg   <= '0;
            free_off_reg     <= '0;
            free_step_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            waveform_reg     <= waveform_next;
            amplitude_reg    <= amplitude_next;
            level_offset_reg <= level_offset_next;
            synced_mode_reg  <= synced_mode_next;
            tempo_bpm_reg    <= tempo_bpm_next;
            rate_mult_reg    <= rate_mult_next;
            sync_off_reg     <= sync_off_next;
            start_time_reg   <= start_time_next;
            free_off_reg     <= free_off_next;
            free_step_reg    <= free_step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg   <= elapsed_next;
        new_step_reg  <= new_step_next;
        tmp_reg       <= tmp_next;
        phase_reg     <= phase_next;
        opnd_reg      <= opnd_next;
        cos_ent_reg   <= cos_ent_next;
        cos_neg_reg   <= cos_neg_next;
        out_level_reg <= out_level_next;
        out_phase_reg <= out_phase_next;
        if (mul_en) prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign result.valid = out_valid_reg;
    assign result.level = out_level_reg;
    assign result.phase = out_phase_reg;

    `ASSERT_ALWAYS(a_state_onehot, $onehot(state_reg), "sequencer state not one-hot")
    `ASSERT_ALWAYS(a_div_done_wait, !div_done || state_reg == S_SYW || state_reg == S_LDIV,
        "divider finished outside a wait step")
    `ASSERT_NEXT(a_fin_delivers, state_reg == S_FIN && (!out_valid_reg || result.ready),
        out_valid_reg && state_reg == S_IDLE, "finished sample not registered")
    `ASSERT_NEXT(a_sync_restart, accept && item.op == lfo_pkg::OP_SYNC,
        start_time_reg == $past(item.time_us) && free_off_reg == 32'd0,
        "sync did not restart the phase")

endmodule
